### design/pair_distance_histogram_assert.svh
// Assertion macros for the pair distance histogram.
// Included by the top level; needs nothing else.
`ifndef PAIR_DISTANCE_HISTOGRAM_ASSERT_SVH
`define PAIR_DISTANCE_HISTOGRAM_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PDH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pair_distance_histogram: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PDH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pair_distance_histogram: assertion failed");

`endif

### design/pdh_pkg.sv
// Shared types and constants for the pair distance histogram.
// Used by pdh_bin_unit and pair_distance_histogram; depends on nothing.
package pdh_pkg;

    localparam int POS_W       = 24;
    localparam int LEN_W       = 23;
    localparam int BINS_REG_W  = 7;
    localparam int BIN_W       = 6;
    localparam int MODE_W      = 2;
    localparam int CLASS_W     = 4;
    localparam int COUNT_OUT_W = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 23;

    // Datapath widths of the distance unit.
    localparam int DIFF_W = 26;            // wrapped axis difference, signed
    localparam int MAG_W  = 25;            // magnitude of the wrapped difference
    localparam int SQ_W   = 52;            // sum of three squares
    localparam int ROOT_W = SQ_W / 2;      // integer square root
    localparam int REM_W  = ROOT_W + 1;    // square root partial remainder
    localparam int SUB_W  = LEN_W + BIN_W; // shared subtractor operand width
    localparam int STEP_W = 5;

    localparam logic [MODE_W-1:0] MODE_ACCUM      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ       = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ_CLEAR = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_BOX_X       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BOX_Y       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BOX_Z       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BIN_WIDTH   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BINS_IN_USE = 3'd4;

    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic [CLASS_W-1:0]      pair_class;
        logic                    same_species;
        logic signed [POS_W-1:0] first_x;
        logic signed [POS_W-1:0] first_y;
        logic signed [POS_W-1:0] first_z;
        logic signed [POS_W-1:0] second_x;
        logic signed [POS_W-1:0] second_y;
        logic signed [POS_W-1:0] second_z;
        logic [BIN_W-1:0]        bin_select;
    } item_t;

    typedef struct packed {
        logic [BIN_W-1:0]       bin_number;
        logic                   counted;
        logic [COUNT_OUT_W-1:0] bin_count;
    } result_t;

    // Status from the distance unit back to the controller.
    typedef struct packed {
        logic             done;
        logic             over;  // quotient is 64 or more, or zero bin width
        logic [BIN_W-1:0] bin;
    } bin_status_t;

endpackage

### design/pair_distance_histogram.sv
// Pair distance histogram: top level with controller, configuration
// registers and counter memory. Depends on pdh_pkg and pdh_bin_unit.
//
// Usage. An item is taken when start is high and busy is low. Mode 0
// bins the distance of an atom pair and bumps that class's counter; modes
// 1 and 2 read one counter, mode 2 also zeroes it. Every item gives exactly
// one result, shown on result for one cycle with done high; the receiver
// cannot stall, so it must take the result in that cycle.
// Accumulate: the unit forms the three squares on one multiplier, then
// runs 26 square root steps, one range check and six division steps on one
// shared subtractor; the controller then does a memory read and write. A
// pair outside the counted bins skips the memory access; one beyond 64 bins
// also skips the division. Reads pass a memory read and an update state; an
// unused mode or out-of-range read answers from idle. busy is low again in
// the cycle done is shown, so the next item can be taken in that cycle.
// Reset: all configuration registers return to their defaults, and a
// clearing pass then zeroes the counter memory one entry per cycle, all
// PAIR_CLASSES * NUM_BINS entries (1024 by default), with busy held high.
// cfg_ready is low while busy, so a configuration write never lands in the
// middle of a transaction; a write in the cycle an item is taken applies to it.
`include "pair_distance_histogram_assert.svh"

module pair_distance_histogram #(
    parameter int NUM_BINS     = 64,
    parameter int PAIR_CLASSES = 16,
    parameter int COUNT_WIDTH  = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  pdh_pkg::item_t                    item,
    output logic                              done,
    output pdh_pkg::result_t                  result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pdh_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [pdh_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import pdh_pkg::*;

    localparam int DEPTH  = NUM_BINS * PAIR_CLASSES;
    localparam int ADDR_W = $clog2(DEPTH);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_CALC   = 5'b00100,
        S_READ   = 5'b01000,
        S_UPDATE = 5'b10000
    } state_t;

    state_t                  state_reg, state_next;
    logic [ADDR_W-1:0]       addr_reg, addr_next;
    logic [BIN_W-1:0]        bin_reg, bin_next;
    item_t                   item_reg;
    result_t                 result_reg, result_next;
    logic                    done_reg, done_next;

    logic [LEN_W-1:0]        box_x_reg, box_y_reg, box_z_reg, bin_width_reg;
    logic [BINS_REG_W-1:0]   bins_in_use_reg;

    logic [COUNT_WIDTH-1:0]  store [DEPTH];
    logic [COUNT_WIDTH-1:0]  rd_data_reg;
    logic                    mem_we;
    logic [COUNT_WIDTH-1:0]  mem_wdata;

    logic                    accept;
    bin_status_t             unit_status;
    logic [CLASS_W-1:0]      addr_class;
    logic [BIN_W-1:0]        addr_bin;
    logic [ADDR_W-1:0]       addr_calc;
    logic                    class_ok, sel_ok, count_ok;
    logic [COUNT_WIDTH:0]    count_sum;
    logic [COUNT_WIDTH-1:0]  count_sat;

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = !busy;

    pdh_bin_unit u_bin_unit (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (accept && (item.mode == MODE_ACCUM)),
        .item      (item_reg),
        .box_x     (box_x_reg),
        .box_y     (box_y_reg),
        .box_z     (box_z_reg),
        .bin_width (bin_width_reg),
        .status    (unit_status)
    );

    // Reads address the store straight from the request; accumulates use
    // the held class and the bin from the distance unit.
    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            addr_class = item.pair_class;
            addr_bin   = item.bin_select;
        end
        else
        begin
            addr_class = item_reg.pair_class;
            addr_bin   = unit_status.bin;
        end
        addr_calc = ADDR_W'(addr_class) * ADDR_W'(NUM_BINS) + ADDR_W'(addr_bin);
        class_ok  = int'(addr_class) < PAIR_CLASSES;
        sel_ok    = int'(item.bin_select) < NUM_BINS;
        count_ok  = !unit_status.over && class_ok
                    && (BINS_REG_W'(unit_status.bin) < bins_in_use_reg)
                    && (int'(unit_status.bin) < NUM_BINS);
    end

    // Saturating increment of the fetched counter.
    always_comb
    begin
        count_sum = {1'b0, rd_data_reg}
                    + (COUNT_WIDTH + 1)'(item_reg.same_species ? 2'd2 : 2'd1);
        count_sat = count_sum[COUNT_WIDTH] ? '1 : count_sum[COUNT_WIDTH-1:0];
    end

    always_comb
    begin
        state_next  = state_reg;
        addr_next   = addr_reg;
        bin_next    = bin_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        mem_we      = 1'b0;
        mem_wdata   = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                addr_next = addr_reg + ADDR_W'(1);
                if (addr_reg == ADDR_W'(DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (item.mode) inside
                        MODE_ACCUM:
                        begin
                            state_next = S_CALC;
                        end
                        MODE_READ, MODE_READ_CLEAR:
                        begin
                            bin_next = item.bin_select;
                            if (class_ok && sel_ok)
                            begin
                                addr_next  = addr_calc;
                                state_next = S_READ;
                            end
                            else
                            begin
                                result_next = '{bin_number: item.bin_select,
                                                counted: 1'b0, bin_count: '0};
                                done_next   = 1'b1;
                            end
                        end
                        default:
                        begin
                            result_next = '0;
                            done_next   = 1'b1;
                        end
                    endcase
                end
            end
            S_CALC:
            begin
                if (unit_status.done)
                begin
                    bin_next = unit_status.bin;
                    if (count_ok)
                    begin
                        addr_next  = addr_calc;
                        state_next = S_READ;
                    end
                    else
                    begin
                        result_next = '{bin_number: unit_status.bin,
                                        counted: 1'b0, bin_count: '0};
                        done_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                unique case (item_reg.mode) inside
                    MODE_ACCUM:
                    begin
                        mem_we      = 1'b1;
                        mem_wdata   = count_sat;
                        result_next = '{bin_number: bin_reg, counted: 1'b1,
                                        bin_count: COUNT_OUT_W'(count_sat)};
                    end
                    MODE_READ, MODE_READ_CLEAR:
                    begin
                        mem_we      = (item_reg.mode == MODE_READ_CLEAR);
                        result_next = '{bin_number: bin_reg, counted: 1'b1,
                                        bin_count: COUNT_OUT_W'(rd_data_reg)};
                    end
                    default:
                    begin
                        result_next = '0;
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            addr_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item;
        bin_reg    <= bin_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_x_reg       <= LEN_W'(4096);
            box_y_reg       <= LEN_W'(4096);
            box_z_reg       <= LEN_W'(4096);
            bin_width_reg   <= LEN_W'(4096);
            bins_in_use_reg <= BINS_REG_W'(50);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BOX_X:       box_x_reg       <= cfg_data[LEN_W-1:0];
                REG_BOX_Y:       box_y_reg       <= cfg_data[LEN_W-1:0];
                REG_BOX_Z:       box_z_reg       <= cfg_data[LEN_W-1:0];
                REG_BIN_WIDTH:   bin_width_reg   <= cfg_data[LEN_W-1:0];
                REG_BINS_IN_USE: bins_in_use_reg <= cfg_data[BINS_REG_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Counter memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            store[addr_reg] <= mem_wdata;
        rd_data_reg <= store[addr_reg];
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Every result is shown while the controller is idle again.
    `PDH_ASSERT_IMPL(a_done_when_idle, clk, rst_n, done, !busy)
    `PDH_ASSERT_IMPL(a_unit_done_in_calc, clk, rst_n, unit_status.done, state_reg == S_CALC)
    `PDH_ASSERT_IMPL(a_counted_in_range, clk, rst_n, done && result.counted && item_reg.mode == MODE_ACCUM, BINS_REG_W'(result.bin_number) < bins_in_use_reg)

endmodule

### design/pdh_bin_unit.sv
// Iterative distance-to-bin unit: minimum-image wrap, sum of squares,
// square root and bin division on one shared subtractor. Depends on pdh_pkg.
module pdh_bin_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         go,
    input  pdh_pkg::item_t               item,
    input  logic [pdh_pkg::LEN_W-1:0]    box_x,
    input  logic [pdh_pkg::LEN_W-1:0]    box_y,
    input  logic [pdh_pkg::LEN_W-1:0]    box_z,
    input  logic [pdh_pkg::LEN_W-1:0]    bin_width,
    output pdh_pkg::bin_status_t         status
);
    import pdh_pkg::*;

    typedef enum logic [6:0] {
        U_IDLE = 7'b0000001,
        U_MAG  = 7'b0000010,
        U_MUL  = 7'b0000100,
        U_ACC  = 7'b0001000,
        U_ROOT = 7'b0010000,
        U_OVER = 7'b0100000,
        U_DIV  = 7'b1000000
    } ustate_t;

    ustate_t                state_reg, state_next;
    logic [1:0]             axis_reg, axis_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [MAG_W-1:0]       mag_reg, mag_next;
    logic [2*MAG_W-1:0]     prod_reg, prod_next;
    logic [SQ_W-1:0]        acc_reg, acc_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic [ROOT_W-1:0]      root_reg, root_next;
    logic [SUB_W-1:0]       div_reg, div_next;
    logic [BIN_W-1:0]       q_reg, q_next;
    bin_status_t            status_reg, status_next;

    logic signed [POS_W-1:0]  pos_a, pos_b;
    logic [LEN_W-1:0]         len;
    logic signed [DIFF_W-1:0] d_raw, d_wrap;
    logic signed [DIFF_W:0]   two_d, len_s;
    logic [MAG_W-1:0]         mag;

    logic [SUB_W-1:0]         sub_a, sub_b;
    logic [SUB_W:0]           sub_full;
    logic                     ge;

    // Axis selection for the wrap step.
    always_comb
    begin
        unique case (axis_reg)
            2'd0:
            begin
                pos_a = item.first_x;
                pos_b = item.second_x;
                len   = box_x;
            end
            2'd1:
            begin
                pos_a = item.first_y;
                pos_b = item.second_y;
                len   = box_y;
            end
            default:
            begin
                pos_a = item.first_z;
                pos_b = item.second_z;
                len   = box_z;
            end
        endcase
    end

    // Minimum image: compare twice the difference against the box length.
    always_comb
    begin
        d_raw = DIFF_W'(pos_b) - DIFF_W'(pos_a);
        two_d = $signed({d_raw, 1'b0});
        len_s = $signed((DIFF_W + 1)'(len));
        if (two_d < -len_s)
            d_wrap = d_raw + DIFF_W'(len_s);
        else if (two_d > len_s)
            d_wrap = d_raw - DIFF_W'(len_s);
        else
            d_wrap = d_raw;
        mag = d_wrap[DIFF_W-1] ? MAG_W'(-d_wrap) : MAG_W'(d_wrap);
    end

    // Shared subtractor for root steps, the range check and division steps.
    always_comb
    begin
        unique case (state_reg)
            U_ROOT:
            begin
                sub_a = {rem_reg, acc_reg[SQ_W-1 -: 2]};
                sub_b = SUB_W'({root_reg, 2'b01});
            end
            U_OVER:
            begin
                sub_a = SUB_W'(root_reg);
                sub_b = {bin_width, BIN_W'(0)};
            end
            U_DIV:
            begin
                sub_a = SUB_W'(rem_reg);
                sub_b = div_reg;
            end
            default:
            begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
        sub_full = {1'b0, sub_a} - {1'b0, sub_b};
        ge       = !sub_full[SUB_W];
    end

    always_comb
    begin
        state_next  = state_reg;
        axis_next   = axis_reg;
        step_next   = step_reg;
        mag_next    = mag_reg;
        prod_next   = prod_reg;
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        root_next   = root_reg;
        div_next    = div_reg;
        q_next      = q_reg;
        status_next = status_reg;
        status_next.done = 1'b0;

        unique case (state_reg)
            U_IDLE:
            begin
                if (go)
                begin
                    axis_next  = 2'd0;
                    acc_next   = '0;
                    state_next = U_MAG;
                end
            end
            U_MAG:
            begin
                mag_next   = mag;
                state_next = U_MUL;
            end
            U_MUL:
            begin
                prod_next  = mag_reg * mag_reg;
                state_next = U_ACC;
            end
            U_ACC:
            begin
                acc_next = acc_reg + SQ_W'(prod_reg);
                if (axis_reg == 2'd2)
                begin
                    rem_next   = '0;
                    root_next  = '0;
                    step_next  = '0;
                    state_next = U_ROOT;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = U_MAG;
                end
            end
            U_ROOT:
            begin
                // One result bit per cycle, two radicand bits shifted in.
                rem_next  = ge ? sub_full[REM_W-1:0] : sub_a[REM_W-1:0];
                root_next = {root_reg[ROOT_W-2:0], ge};
                acc_next  = acc_reg << 2;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(ROOT_W - 1))
                    state_next = U_OVER;
            end
            U_OVER:
            begin
                if (ge)
                begin
                    status_next = '{done: 1'b1, over: 1'b1, bin: '1};
                    state_next  = U_IDLE;
                end
                else
                begin
                    rem_next   = REM_W'(root_reg);
                    div_next   = {bin_width, BIN_W'(0)} >> 1;
                    q_next     = '0;
                    step_next  = STEP_W'(BIN_W - 1);
                    state_next = U_DIV;
                end
            end
            U_DIV:
            begin
                if (ge)
                    rem_next = sub_full[REM_W-1:0];
                q_next   = {q_reg[BIN_W-2:0], ge};
                div_next = div_reg >> 1;
                if (step_reg == '0)
                begin
                    status_next = '{done: 1'b1, over: 1'b0, bin: {q_reg[BIN_W-2:0], ge}};
                    state_next  = U_IDLE;
                end
                else
                begin
                    step_next = step_reg - STEP_W'(1);
                end
            end
            default:
            begin
                state_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= U_IDLE;
            axis_reg   <= '0;
            step_reg   <= '0;
            status_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            axis_reg   <= axis_next;
            step_reg   <= step_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        div_reg  <= div_next;
        q_reg    <= q_next;
    end

    assign status = status_reg;

endmodule
